// File: sv/cps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Close phoneme substitution package
// Shared field widths, command codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int CODE_W       = 7;
  localparam int POS_W        = 6;
  localparam int LEN_W        = 7;
  localparam int DIST_W       = 5;
  localparam int LOAD_W       = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 7;
  localparam int CNT_W        = 7;
  localparam int RESULT_LIMIT = 64;

  typedef enum logic [1:0] {
    FN_LOAD_MASK = 2'd0,
    FN_LOAD_FEAT = 2'd1,
    FN_LOAD_ALPH = 2'd2,
    FN_QUERY     = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DISTANCE  = 3'd0,
    REG_RHYME_MODE    = 3'd1,
    REG_FIXED_TAIL    = 3'd2,
    REG_FEATURE_COUNT = 3'd3,
    REG_ALPHABET_SIZE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYM,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic issue_en;
    logic qual;
    logic emit_mid;
    logic emit_last;
  } walk_ctl_t;

endpackage

// File: sv/cps_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature distance unit
// Holds the feature group masks, registers the per-group overlap hits for one
// feature difference word and counts them into a distance.
// ----------------------------------------------------------------------------
module cps_dist #(
  parameter int GROUPS = 16,
  parameter int FBITS  = 32,
  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1,
  localparam int DW    = $clog2(GROUPS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      mask_we,
  input  logic [GW-1:0]             mask_idx,
  input  logic [FBITS-1:0]          mask_data,
  input  logic [cps_pkg::DIST_W-1:0] feat_count,
  input  logic [FBITS-1:0]          diff,
  output logic [DW-1:0]             hit_sum
);

  logic [FBITS-1:0] mask_r [GROUPS];
  logic [GROUPS-1:0] hits_nxt;
  logic [GROUPS-1:0] hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GROUPS; g++) begin
        mask_r[g] <= '0;
      end
    end else if (mask_we) begin
      for (int g = 0; g < GROUPS; g++) begin
        if (mask_idx == GW'(g)) begin
          mask_r[g] <= mask_data;
        end
      end
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      hits_nxt[g] = (|(diff & mask_r[g])) && (6'(g) < {1'b0, feat_count});
    end
  end

  always_ff @(posedge clk) begin
    hits_r <= hits_nxt;
  end

  always_comb begin
    hit_sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      hit_sum = hit_sum + DW'(hits_r[g]);
    end
  end

endmodule

// File: sv/close_phoneme_substitution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Close phoneme substitution
// Lists the alphabet phonemes that lie within a feature distance of a queried
// phoneme, for one position of a word.
// ----------------------------------------------------------------------------
// Commands enter on start with the in_ fields and are taken when busy is low.
// Load commands write the group mask registers, the phoneme feature memory or
// the alphabet memory and produce no beat. A query whose position may not be
// changed is dropped at once and leaves busy low. A modifiable query raises
// busy, reads the symbol features, then streams the alphabet memory one entry
// per cycle through a four stage read, feature read, group match and count
// pipeline. Each substitute is one out_valid beat; the last beat of a query
// has out_last set and appears in the first cycle with busy low again. While
// a query walks, one alphabet entry and one feature word are read per cycle.
// The receiver has no way to stall the output, and beats come at most one per
// cycle. Configuration writes on the cfg_ channel are taken every cycle and
// belong to idle periods. Reset sets the configuration registers to their
// defaults and clears the feature and alphabet tables at once through
// per-entry valid bits; the group masks are cleared to zero directly.
// ----------------------------------------------------------------------------
module close_phoneme_substitution #(
  parameter int FEATURE_GROUPS = 16,
  parameter int ALPHABET_DEPTH = 64,
  parameter int CODE_SPACE     = 128,
  parameter int FEATURE_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [cps_pkg::CODE_W-1:0]    in_index,
  input  logic [cps_pkg::LOAD_W-1:0]    in_load_value,
  input  logic [cps_pkg::CODE_W-1:0]    in_symbol,
  input  logic [cps_pkg::POS_W-1:0]     in_position,
  input  logic [cps_pkg::LEN_W-1:0]     in_word_length,
  output logic                          out_valid,
  output logic [cps_pkg::POS_W-1:0]     out_position,
  output logic [cps_pkg::CODE_W-1:0]    out_replacement,
  output logic [cps_pkg::DIST_W-1:0]    out_distance,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(ALPHABET_DEPTH);
  localparam int IW = $clog2(ALPHABET_DEPTH + 1);
  localparam int FW = $clog2(CODE_SPACE);
  localparam int GW = (FEATURE_GROUPS > 1) ? $clog2(FEATURE_GROUPS) : 1;
  localparam int DW = $clog2(FEATURE_GROUPS + 1);

  cps_pkg::state_t    state_r;
  cps_pkg::state_t    state_nxt;
  cps_pkg::walk_ctl_t ctl;

  logic [cps_pkg::DIST_W-1:0]  max_dist_r;
  logic                        rhyme_r;
  logic [cps_pkg::LEN_W-1:0]   fixed_tail_r;
  logic [cps_pkg::DIST_W-1:0]  feat_count_r;
  logic [cps_pkg::LEN_W-1:0]   alph_size_r;

  logic                        acc;
  logic [8:0]                  idx9;
  logic [63:0]                 load_ext;
  logic [FEATURE_BITS-1:0]     load_data;
  logic                        ld_mask;
  logic                        ld_feat;
  logic                        ld_alph;
  logic [7:0]                  pos8;
  logic [7:0]                  len8;
  logic [7:0]                  ft8;
  logic                        modifiable;
  logic                        q_go;

  logic [cps_pkg::CODE_W-1:0]  alph_mem [ALPHABET_DEPTH];
  logic [ALPHABET_DEPTH-1:0]   alph_vld_r;
  logic [cps_pkg::CODE_W-1:0]  alph_q_r;
  logic                        alph_qv_r;

  logic [FEATURE_BITS-1:0]     feat_mem [CODE_SPACE];
  logic [CODE_SPACE-1:0]       feat_vld_r;
  logic [FEATURE_BITS-1:0]     feat_q_r;
  logic                        feat_qv_r;
  logic                        feat_inr_r;
  logic [8:0]                  feat_code9;
  logic [FW-1:0]               feat_rd_addr;
  logic [FEATURE_BITS-1:0]     feat_word;

  logic [cps_pkg::CODE_W-1:0]  sym_r;
  logic [cps_pkg::POS_W-1:0]   pos_r;
  logic [IW-1:0]               walk_r;
  logic [IW-1:0]               issue_cnt_r;
  logic [FEATURE_BITS-1:0]     sym_feat_r;

  logic                        s1_vld_r;
  logic                        s2_vld_r;
  logic                        s3_vld_r;
  logic [cps_pkg::CODE_W-1:0]  code1;
  logic [cps_pkg::CODE_W-1:0]  s2_code_r;
  logic                        s2_eq_r;
  logic [cps_pkg::CODE_W-1:0]  s3_code_r;
  logic                        s3_eq_r;
  logic [DW-1:0]               grp_dist;
  logic [5:0]                  dist6;
  logic [cps_pkg::DIST_W-1:0]  dist_sat;

  logic                        pend_vld_r;
  logic [cps_pkg::CODE_W-1:0]  pend_code_r;
  logic [cps_pkg::DIST_W-1:0]  pend_dist_r;
  logic [cps_pkg::CNT_W-1:0]   qual_cnt_r;
  logic                        limit_hit;
  logic                        drained;

  assign busy      = (state_r != cps_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  assign idx9      = {2'b00, in_index};
  assign load_ext  = 64'(in_load_value);
  assign load_data = load_ext[FEATURE_BITS-1:0];
  assign ld_mask   = acc && (in_func == cps_pkg::FN_LOAD_MASK) && (idx9 < 9'(FEATURE_GROUPS));
  assign ld_feat   = acc && (in_func == cps_pkg::FN_LOAD_FEAT) && (idx9 < 9'(CODE_SPACE));
  assign ld_alph   = acc && (in_func == cps_pkg::FN_LOAD_ALPH) && (idx9 < 9'(ALPHABET_DEPTH));

  assign pos8 = {2'b00, in_position};
  assign len8 = {1'b0, in_word_length};
  assign ft8  = {1'b0, fixed_tail_r};

  always_comb begin
    if (!rhyme_r) begin
      modifiable = (pos8 < len8);
    end else if (fixed_tail_r < in_word_length) begin
      modifiable = ((pos8 + ft8) < len8);
    end else begin
      modifiable = ((pos8 + 8'd1) < len8);
    end
  end

  assign q_go = acc && (in_func == cps_pkg::FN_QUERY) && modifiable;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r   <= 5'd1;
      rhyme_r      <= 1'b0;
      fixed_tail_r <= '0;
      feat_count_r <= '0;
      alph_size_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cps_pkg::REG_MAX_DISTANCE:  max_dist_r   <= cfg_data[cps_pkg::DIST_W-1:0];
        cps_pkg::REG_RHYME_MODE:    rhyme_r      <= cfg_data[0];
        cps_pkg::REG_FIXED_TAIL:    fixed_tail_r <= cfg_data;
        cps_pkg::REG_FEATURE_COUNT: feat_count_r <= cfg_data[cps_pkg::DIST_W-1:0];
        cps_pkg::REG_ALPHABET_SIZE: alph_size_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld_alph) begin
      alph_mem[idx9[AW-1:0]] <= load_ext[cps_pkg::CODE_W-1:0];
    end
    alph_q_r <= alph_mem[issue_cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alph_vld_r <= '0;
      alph_qv_r  <= 1'b0;
    end else begin
      if (ld_alph) begin
        alph_vld_r[idx9[AW-1:0]] <= 1'b1;
      end
      alph_qv_r <= alph_vld_r[issue_cnt_r[AW-1:0]];
    end
  end

  assign code1        = alph_qv_r ? alph_q_r : '0;
  assign feat_code9   = (state_r == cps_pkg::ST_IDLE) ? {2'b00, in_symbol} : {2'b00, code1};
  assign feat_rd_addr = feat_code9[FW-1:0];

  always_ff @(posedge clk) begin
    if (ld_feat) begin
      feat_mem[idx9[FW-1:0]] <= load_data;
    end
    feat_q_r   <= feat_mem[feat_rd_addr];
    feat_inr_r <= (feat_code9 < 9'(CODE_SPACE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_vld_r <= '0;
      feat_qv_r  <= 1'b0;
    end else begin
      if (ld_feat) begin
        feat_vld_r[idx9[FW-1:0]] <= 1'b1;
      end
      feat_qv_r <= feat_vld_r[feat_rd_addr];
    end
  end

  assign feat_word = (feat_qv_r && feat_inr_r) ? feat_q_r : '0;

  cps_dist #(
    .GROUPS (FEATURE_GROUPS),
    .FBITS  (FEATURE_BITS)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .mask_we    (ld_mask),
    .mask_idx   (idx9[GW-1:0]),
    .mask_data  (load_data),
    .feat_count (feat_count_r),
    .diff       (feat_word ^ sym_feat_r),
    .hit_sum    (grp_dist)
  );

  assign dist6    = 6'(grp_dist);
  assign dist_sat = (dist6 > 6'd31) ? 5'd31 : dist6[cps_pkg::DIST_W-1:0];

  assign limit_hit = (qual_cnt_r == cps_pkg::CNT_W'(cps_pkg::RESULT_LIMIT));
  assign drained   = (issue_cnt_r == walk_r) && !s1_vld_r && !s2_vld_r && !s3_vld_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cps_pkg::ST_IDLE: begin
        if (q_go) begin
          state_nxt = cps_pkg::ST_SYM;
        end
      end
      cps_pkg::ST_SYM:  state_nxt = cps_pkg::ST_WALK;
      cps_pkg::ST_WALK: begin
        if (limit_hit || drained) begin
          state_nxt = cps_pkg::ST_FLUSH;
        end
      end
      cps_pkg::ST_FLUSH: state_nxt = cps_pkg::ST_IDLE;
      default: state_nxt = cps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.issue_en  = ((state_r == cps_pkg::ST_SYM) || (state_r == cps_pkg::ST_WALK))
                    && (issue_cnt_r < walk_r) && !limit_hit;
    ctl.qual      = (state_r == cps_pkg::ST_WALK) && s3_vld_r && !s3_eq_r
                    && (dist6 <= {1'b0, max_dist_r}) && !limit_hit;
    ctl.emit_mid  = ctl.qual && pend_vld_r;
    ctl.emit_last = (state_r == cps_pkg::ST_FLUSH) && pend_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cps_pkg::ST_IDLE;
      issue_cnt_r <= '0;
      qual_cnt_r  <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      s1_vld_r  <= ctl.issue_en;
      s2_vld_r  <= s1_vld_r && (state_r != cps_pkg::ST_FLUSH);
      s3_vld_r  <= s2_vld_r && (state_r != cps_pkg::ST_FLUSH);
      out_valid <= ctl.emit_mid || ctl.emit_last;
      if (q_go) begin
        issue_cnt_r <= '0;
        qual_cnt_r  <= '0;
      end else begin
        if (ctl.issue_en) begin
          issue_cnt_r <= issue_cnt_r + IW'(1);
        end
        if (ctl.qual) begin
          qual_cnt_r <= qual_cnt_r + cps_pkg::CNT_W'(1);
        end
      end
      if (state_r == cps_pkg::ST_FLUSH) begin
        pend_vld_r <= 1'b0;
      end else if (ctl.qual) begin
        pend_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_go) begin
      sym_r  <= in_symbol;
      pos_r  <= in_position;
      walk_r <= ({1'b0, alph_size_r} > 8'(ALPHABET_DEPTH)) ? IW'(ALPHABET_DEPTH)
                                                            : IW'(alph_size_r);
    end
    if (state_r == cps_pkg::ST_SYM) begin
      sym_feat_r <= feat_word;
    end
    s2_code_r <= code1;
    s2_eq_r   <= (code1 == sym_r);
    s3_code_r <= s2_code_r;
    s3_eq_r   <= s2_eq_r;
    if (ctl.qual) begin
      pend_code_r <= s3_code_r;
      pend_dist_r <= dist_sat;
    end
    out_position    <= pos_r;
    out_replacement <= pend_code_r;
    out_distance    <= pend_dist_r;
    out_last        <= ctl.emit_last;
  end

  a_out_from_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == cps_pkg::ST_WALK || $past(state_r) == cps_pkg::ST_FLUSH))
    else $error("result beat without an active query");

  a_last_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (state_r == cps_pkg::ST_IDLE))
    else $error("query still active after its last beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qual_cnt_r <= cps_pkg::CNT_W'(cps_pkg::RESULT_LIMIT))
    else $error("substitute count beyond limit");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cps_pkg::ST_IDLE) |-> (!pend_vld_r && !s1_vld_r && !s2_vld_r && !s3_vld_r))
    else $error("stale pipeline state while idle");

  a_flush_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cps_pkg::ST_FLUSH) |=> (state_r == cps_pkg::ST_IDLE))
    else $error("flush did not return to idle");

endmodule

// File: tb/close_phoneme_substitution_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Close phoneme substitution testbench
// Loads the mask, feature and alphabet tables and sends queries under several
// register settings and sender idle rates. A scoreboard keeps its own copy of
// the tables and registers, works out the substitutes of every accepted query
// and checks each result beat against them in order.
// ----------------------------------------------------------------------------
module close_phoneme_substitution_test;

  localparam int POOL_SIZE    = 12;
  localparam int QUIET_CYCLES = 80;

  typedef struct {
    logic [cps_pkg::POS_W-1:0]  position;
    logic [cps_pkg::CODE_W-1:0] replacement;
    logic [cps_pkg::DIST_W-1:0] distance;
    logic                       last;
  } substitute_t;

  class substitution_board;
    localparam int GROUPS   = 16;
    localparam int CODES    = 128;
    localparam int ALPHABET = 64;

    logic [cps_pkg::LOAD_W-1:0] group_mask [GROUPS];
    logic [cps_pkg::LOAD_W-1:0] features [CODES];
    logic [cps_pkg::CODE_W-1:0] alphabet [ALPHABET];
    logic [4:0]                 max_distance;
    logic                       rhyme_mode;
    logic [6:0]                 fixed_tail;
    logic [4:0]                 feature_count;
    logic [6:0]                 alphabet_size;
    substitute_t                pending [$];
    int                         errors;

    function new();
      foreach (group_mask[g]) group_mask[g] = '0;
      foreach (features[c]) features[c] = '0;
      foreach (alphabet[a]) alphabet[a] = '0;
      max_distance  = 5'd1;
      rhyme_mode    = 1'b0;
      fixed_tail    = '0;
      feature_count = '0;
      alphabet_size = '0;
      errors        = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function void set_reg(cps_pkg::cfg_reg_t r, logic [cps_pkg::CFG_DATA_W-1:0] v);
      case (r)
        cps_pkg::REG_MAX_DISTANCE:  max_distance  = v[4:0];
        cps_pkg::REG_RHYME_MODE:    rhyme_mode    = v[0];
        cps_pkg::REG_FIXED_TAIL:    fixed_tail    = v;
        cps_pkg::REG_FEATURE_COUNT: feature_count = v[4:0];
        cps_pkg::REG_ALPHABET_SIZE: alphabet_size = v;
        default: ;
      endcase
    endfunction

    function int group_distance(logic [cps_pkg::CODE_W-1:0] a,
                                logic [cps_pkg::CODE_W-1:0] b);
      logic [cps_pkg::LOAD_W-1:0] diff;
      int n;
      int d;
      diff = features[a] ^ features[b];
      n = (feature_count > GROUPS) ? GROUPS : int'(feature_count);
      d = 0;
      for (int g = 0; g < n; g++)
        if ((diff & group_mask[g]) != '0) d++;
      return d;
    endfunction

    function bit may_change(logic [cps_pkg::POS_W-1:0] pos, logic [cps_pkg::LEN_W-1:0] len);
      int limit;
      if (!rhyme_mode) limit = int'(len);
      else if (fixed_tail < len) limit = int'(len) - int'(fixed_tail);
      else limit = int'(len) - 1;
      return int'(pos) < limit;
    endfunction

    function void note_command(cps_pkg::func_t f, logic [cps_pkg::CODE_W-1:0] idx,
                               logic [cps_pkg::LOAD_W-1:0] val,
                               logic [cps_pkg::CODE_W-1:0] sym,
                               logic [cps_pkg::POS_W-1:0] pos,
                               logic [cps_pkg::LEN_W-1:0] len);
      substitute_t                found [$];
      substitute_t                s;
      int                         walk;
      int                         d;
      logic [cps_pkg::CODE_W-1:0] code;
      case (f)
        cps_pkg::FN_LOAD_MASK: if (idx < GROUPS) group_mask[idx] = val;
        cps_pkg::FN_LOAD_FEAT: features[idx] = val;
        cps_pkg::FN_LOAD_ALPH: if (idx < ALPHABET) alphabet[idx] = val[cps_pkg::CODE_W-1:0];
        cps_pkg::FN_QUERY: begin
          if (may_change(pos, len)) begin
            walk = (alphabet_size > ALPHABET) ? ALPHABET : int'(alphabet_size);
            for (int i = 0; i < walk && found.size() < cps_pkg::RESULT_LIMIT; i++) begin
              code = alphabet[i];
              if (code != sym) begin
                d = group_distance(sym, code);
                if (d <= int'(max_distance)) begin
                  s.position    = pos;
                  s.replacement = code;
                  s.distance    = (d > 31) ? 5'd31 : 5'(d);
                  s.last        = 1'b0;
                  found.push_back(s);
                end
              end
            end
            foreach (found[k]) begin
              s = found[k];
              s.last = (k == found.size() - 1);
              pending.push_back(s);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_beat(logic [cps_pkg::POS_W-1:0] pos, logic [cps_pkg::CODE_W-1:0] repl,
                    logic [cps_pkg::DIST_W-1:0] got_dist, logic last);
      substitute_t want;
      if (pending.size() == 0) begin
        report($sformatf("beat with nothing expected: position %0d code %0d", pos, repl));
        return;
      end
      want = pending.pop_front();
      if (pos !== want.position)
        report($sformatf("position %0d, wanted %0d", pos, want.position));
      if (repl !== want.replacement)
        report($sformatf("replacement %0d, wanted %0d", repl, want.replacement));
      if (got_dist !== want.distance)
        report($sformatf("distance %0d, wanted %0d (code %0d)", got_dist, want.distance,
                         want.replacement));
      if (last !== want.last)
        report($sformatf("last %0b, wanted %0b (code %0d)", last, want.last,
                         want.replacement));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [1:0]                     in_func = '0;
  logic [cps_pkg::CODE_W-1:0]     in_index = '0;
  logic [cps_pkg::LOAD_W-1:0]     in_load_value = '0;
  logic [cps_pkg::CODE_W-1:0]     in_symbol = '0;
  logic [cps_pkg::POS_W-1:0]      in_position = '0;
  logic [cps_pkg::LEN_W-1:0]      in_word_length = '0;
  logic                           out_valid;
  logic [cps_pkg::POS_W-1:0]      out_position;
  logic [cps_pkg::CODE_W-1:0]     out_replacement;
  logic [cps_pkg::DIST_W-1:0]     out_distance;
  logic                           out_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  substitution_board board = new();
  logic [cps_pkg::LOAD_W-1:0] base_features;
  logic [cps_pkg::CODE_W-1:0] pool [POOL_SIZE];

  close_phoneme_substitution DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_index(in_index),
    .in_load_value(in_load_value),
    .in_symbol(in_symbol),
    .in_position(in_position),
    .in_word_length(in_word_length),
    .out_valid(out_valid),
    .out_position(out_position),
    .out_replacement(out_replacement),
    .out_distance(out_distance),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_beat(out_position, out_replacement, out_distance, out_last);
      if (start && !busy)
        board.note_command(cps_pkg::func_t'(in_func), in_index, in_load_value, in_symbol,
                           in_position, in_word_length);
      if (cfg_valid && cfg_ready) board.set_reg(cps_pkg::cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  task automatic send_item(cps_pkg::func_t f, logic [cps_pkg::CODE_W-1:0] idx,
                           logic [cps_pkg::LOAD_W-1:0] val,
                           logic [cps_pkg::CODE_W-1:0] sym,
                           logic [cps_pkg::POS_W-1:0] pos,
                           logic [cps_pkg::LEN_W-1:0] len, int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start          = 1'b1;
    in_func        = f;
    in_index       = idx;
    in_load_value  = val;
    in_symbol      = sym;
    in_position    = pos;
    in_word_length = len;
    do @(posedge clk); while (busy);
  endtask

  task automatic query(logic [cps_pkg::CODE_W-1:0] sym, logic [cps_pkg::POS_W-1:0] pos,
                       logic [cps_pkg::LEN_W-1:0] len);
    send_item(cps_pkg::FN_QUERY, 7'($urandom), $urandom, sym, pos, len, 0);
  endtask

  task automatic load(cps_pkg::func_t f, logic [cps_pkg::CODE_W-1:0] idx,
                      logic [cps_pkg::LOAD_W-1:0] val);
    send_item(f, idx, val, 7'($urandom), 6'($urandom), 7'($urandom), 0);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cps_pkg::cfg_reg_t r, int v);
    logic [cps_pkg::CFG_DATA_W-1:0] data;
    data = 7'($urandom);
    case (r)
      cps_pkg::REG_MAX_DISTANCE, cps_pkg::REG_FEATURE_COUNT: data[4:0] = 5'(v);
      cps_pkg::REG_RHYME_MODE: data[0] = v[0];
      default: data = 7'(v);
    endcase
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(int max_dist, int rhyme, int tail, int groups, int walk);
    write_reg(cps_pkg::REG_MAX_DISTANCE, max_dist);
    write_reg(cps_pkg::REG_RHYME_MODE, rhyme);
    write_reg(cps_pkg::REG_FIXED_TAIL, tail);
    write_reg(cps_pkg::REG_FEATURE_COUNT, groups);
    write_reg(cps_pkg::REG_ALPHABET_SIZE, walk);
  endtask

  function automatic logic [cps_pkg::LOAD_W-1:0] near_base();
    logic [cps_pkg::LOAD_W-1:0] v;
    v = base_features;
    repeat ($urandom_range(3)) v ^= 32'h1 << $urandom_range(31);
    return v;
  endfunction

  task automatic random_item(int idle_pct);
    int                         pick;
    cps_pkg::func_t             f;
    logic [cps_pkg::CODE_W-1:0] idx;
    logic [cps_pkg::LOAD_W-1:0] val;
    logic [cps_pkg::CODE_W-1:0] sym;
    logic [cps_pkg::POS_W-1:0]  pos;
    logic [cps_pkg::LEN_W-1:0]  len;
    pick = $urandom_range(99);
    idx  = 7'($urandom);
    val  = $urandom;
    sym  = 7'($urandom);
    pos  = 6'($urandom);
    len  = 7'($urandom_range(1, 64));
    if (pick < 60) begin
      f = cps_pkg::FN_QUERY;
      if ($urandom_range(9) < 8) sym = pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(9) == 0) len = 7'($urandom_range(127));
      else if ($urandom_range(2) == 0) pos = 6'($urandom_range(len - 1));
    end else if (pick < 78) begin
      f = cps_pkg::FN_LOAD_FEAT;
      if ($urandom_range(3) != 0) idx = pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(7) != 0) val = near_base();
    end else if (pick < 92) begin
      f = cps_pkg::FN_LOAD_ALPH;
      idx = 7'($urandom_range(79));
      if ($urandom_range(1) == 0) val[31:7] = '0;
      if ($urandom_range(7) != 0) val[6:0] = pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      f = cps_pkg::FN_LOAD_MASK;
      idx = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(15));
      if ($urandom_range(3) != 0) val = 32'h3 << (2 * $urandom_range(15));
    end
    send_item(f, idx, val, sym, pos, len, idle_pct);
  endtask

  task automatic run_random(int count, int idle_pct, bit pressure);
    for (int i = 0; i < count; i++) begin
      if (pressure && (i == count / 2 || $urandom_range(24) == 0)) settle();
      random_item(idle_pct);
    end
    settle();
  endtask

  initial begin
    #5_000_000;
    $display("close_phoneme_substitution: mismatch");
    $finish;
  end

  initial begin
    base_features = $urandom;
    foreach (pool[i]) pool[i] = 7'($urandom_range(1, 127));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings walk no alphabet entries, so this query yields nothing.
    query(pool[0], 6'd0, 7'd1);
    load(cps_pkg::FN_LOAD_MASK, 7'd0, 32'h0000_0003);
    load(cps_pkg::FN_LOAD_MASK, 7'd15, 32'hC000_0000);
    load(cps_pkg::FN_LOAD_MASK, 7'd16, 32'hFFFF_FFFF);
    load(cps_pkg::FN_LOAD_MASK, 7'd127, 32'hFFFF_FFFF);
    load(cps_pkg::FN_LOAD_FEAT, 7'd0, 32'h0);
    load(cps_pkg::FN_LOAD_FEAT, 7'd127, 32'hFFFF_FFFF);
    load(cps_pkg::FN_LOAD_FEAT, pool[0], base_features);
    load(cps_pkg::FN_LOAD_ALPH, 7'd0, 32'hFFFF_FF80 | pool[0]);
    load(cps_pkg::FN_LOAD_ALPH, 7'd63, 32'd127);
    load(cps_pkg::FN_LOAD_ALPH, 7'd64, 32'd5);
    load(cps_pkg::FN_LOAD_ALPH, 7'd127, 32'd9);
    settle();

    configure(16, 0, 0, 16, 64);
    query(7'd0, 6'd63, 7'd64);
    query(7'd127, 6'd0, 7'd64);
    query(pool[1], 6'd0, 7'd0);
    query(pool[1], 6'd5, 7'd5);
    settle();

    configure(0, 1, 3, 16, 64);
    query(pool[1], 6'd1, 7'd5);
    query(pool[1], 6'd2, 7'd5);
    settle();
    write_reg(cps_pkg::REG_FIXED_TAIL, 64);
    query(pool[1], 6'd62, 7'd64);
    query(pool[1], 6'd63, 7'd64);
    settle();
    write_reg(cps_pkg::REG_FIXED_TAIL, 127);
    query(pool[1], 6'd63, 7'd127);
    query(pool[1], 6'd0, 7'd0);
    settle();

    configure(2, 0, 0, 16, 16);
    run_random(47, 0, 1'b0);
    configure(3, 1, 2, 8, 32);
    run_random(47, 88, 1'b0);
    configure(31, 0, 127, 31, 127);
    run_random(47, 23, 1'b0);
    configure($urandom_range(4), 1, $urandom_range(70), $urandom_range(20),
              $urandom_range(1, 70));
    run_random(47, 0, 1'b1);

    if (board.errors == 0 && board.pending.size() == 0)
      $display("close_phoneme_substitution: match");
    else
      $display("close_phoneme_substitution: mismatch");
    $finish;
  end

endmodule
